@@ design/sorted_priority_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Payload structs, entry type, cell control and status and command codes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic               cmd;
		logic signed [31:0] item_value;
		logic signed [31:0] item_priority;
	} op_t;

	typedef struct packed {
		logic signed [31:0] head_value;
		logic signed [31:0] head_priority;
		logic [1:0]         status;
		logic [3:0]         entry_count;
	} result_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] prio;
	} entry_t;

	// Broadcast to every cell for one operation that changes the queue.
	typedef struct packed {
		logic enq;
		logic deq;
	} cell_ctrl_t;

endpackage

@@ design/spq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's, and on removal it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  entry_t     new_entry,
	input  entry_t     left_entry,
	input  logic       left_keep,
	input  entry_t     right_entry,
	input  logic       occupied,
	output entry_t     entry,
	output logic       keep
);

	entry_t entry_q;

	// A held entry stays put unless the newcomer strictly outranks it.
	assign keep  = occupied && !($signed(new_entry.prio) > $signed(entry_q.prio));
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (!keep) begin
				entry_q <= left_keep ? new_entry : left_entry;
			end
		end else if (ctrl.deq) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ design/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded queue of value and priority pairs, served highest priority first.
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH cells kept in descending priority order, the
// head in cell 0. On an enqueue each cell compares the new priority with its
// own in parallel and either keeps its entry, takes the new one, or takes its
// left neighbor's; on a dequeue every cell takes its right neighbor's entry.
// New entries go behind all entries of equal priority, so equal priorities
// leave in arrival order. One operation is accepted per cycle as long as the
// result register is free or is being drained in the same cycle; each
// operation gives exactly one result in the cycle after its transfer. A full
// queue drops an enqueue with status full, an empty queue answers a dequeue
// with status empty, and every result carries the entry count after the
// operation (low four bits).
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    op_valid,
	output logic    op_stall,
	input  op_t     op,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          result_valid_q;
	result_t       result_q;

	logic       op_xfer;
	logic       is_full;
	logic       is_empty;
	logic       do_enq;
	logic       do_deq;
	cell_ctrl_t ctrl;
	entry_t     new_entry;
	logic [CW+3:0] count_wide;

	entry_t     cell_entry [DEPTH];
	logic       cell_keep  [DEPTH];

	// The input side waits only while a finished result is held and stalled.
	assign op_stall = result_valid_q && result_stall;
	assign op_xfer  = op_valid && !op_stall;

	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign do_enq   = op_xfer && (op.cmd == CMD_ENQUEUE) && !is_full;
	assign do_deq   = op_xfer && (op.cmd == CMD_DEQUEUE) && !is_empty;

	assign ctrl.enq = do_enq;
	assign ctrl.deq = do_deq;

	assign new_entry.value = op.item_value;
	assign new_entry.prio  = op.item_priority;

	// The row of cells. Cell 0 always sees a "left neighbor keeps" so that an
	// enqueue that outranks the head lands there; the last cell shifts in zero.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		logic   left_k;
		entry_t right_e;

		if (i == 0) begin : g_first
			assign left_e = new_entry;
			assign left_k = 1'b1;
		end else begin : g_inner_left
			assign left_e = cell_entry[i-1];
			assign left_k = cell_keep[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner_right
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.left_keep   (left_k),
			.right_entry (right_e),
			.occupied    (count_q > CW'(i)),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	always_comb begin
		count_next = count_q;
		if (do_enq) begin
			count_next = count_q + CW'(1);
		end else if (do_deq) begin
			count_next = count_q - CW'(1);
		end
	end

	assign count_wide = {4'b0000, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (op_xfer) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The result register loads on every transfer; the head is read from
	// cell 0 before the shift takes effect.
	always_ff @(posedge clk) begin
		if (op_xfer) begin
			result_q.head_value    <= do_deq ? cell_entry[0].value : '0;
			result_q.head_priority <= do_deq ? cell_entry[0].prio : '0;
			result_q.entry_count   <= count_wide[3:0];
			if (op.cmd == CMD_ENQUEUE) begin
				result_q.status <= is_full ? STATUS_FULL : STATUS_DONE;
			end else begin
				result_q.status <= is_empty ? STATUS_EMPTY : STATUS_DONE;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`include "sorted_priority_queue_assert.svh"

	`SPQ_ASSERT_NEXT(a_enq_grows, do_enq, count_q == $past(count_q) + CW'(1), "enqueue did not grow the count")
	`SPQ_ASSERT_NEXT(a_deq_head, do_deq, result_q.head_priority == $past(cell_entry[0].prio), "dequeue reported a wrong head")
	`SPQ_ASSERT_SAME(a_empty_zero, result_valid_q && result_q.status == STATUS_EMPTY, result_q.head_value == '0 && result_q.entry_count == 4'd0, "empty dequeue result not zero")
	`SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")

endmodule

@@ tb/tb_sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Checks each result against a shadow queue under directed and random traffic.
// ----------------------------------------------------------------------------
// The testbench keeps its own copy of the queue: a row of entries in
// descending priority order and a count. Each operation is applied to this
// copy at the moment its transfer is seen, and the result that the block must
// give is pushed onto a queue of pending results. A checker compares every
// result transfer field by field with the oldest pending result.
//
// The directed tests cover a dequeue on an empty queue, the extremes of the
// value and priority fields, ties in priority (which must leave in arrival
// order), an enqueue dropped on a full queue and a full drain. The random
// test then runs in four phases with different amounts of sender idling and
// receiver stalling, steering the queue between full and empty.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int DEPTH          = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 8;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    op_valid     = 1'b0;
	logic    op_stall;
	op_t     op           = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int idle_pct  = 0;
	int stall_pct = 0;

	// Shadow copy of the queue contents, head at index 0.
	entry_t  shadow_entries [DEPTH];
	int      shadow_count = 0;
	result_t pending_results [$];

	int fail_count  = 0;
	int idle_cycles = 0;

	sorted_priority_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (op_valid),
		.op_stall    (op_stall),
		.op          (op),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	// Applies one operation to the shadow queue and returns the result that
	// the block must give for it. A new entry goes behind every entry of
	// greater or equal priority; a dequeue shifts every entry up by one.
	function automatic result_t apply_queue_op(input op_t o);
		result_t r;
		int      pos;
		r = '0;
		if (o.cmd == CMD_ENQUEUE) begin
			if (shadow_count >= DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				pos = shadow_count;
				while (pos > 0 && o.item_priority > shadow_entries[pos - 1].prio) begin
					shadow_entries[pos] = shadow_entries[pos - 1];
					pos--;
				end
				shadow_entries[pos].value = o.item_value;
				shadow_entries[pos].prio  = o.item_priority;
				shadow_count++;
				r.status = STATUS_DONE;
			end
		end else begin
			if (shadow_count == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				r.head_value    = shadow_entries[0].value;
				r.head_priority = shadow_entries[0].prio;
				for (int k = 0; k + 1 < shadow_count; k++)
					shadow_entries[k] = shadow_entries[k + 1];
				shadow_count--;
				shadow_entries[shadow_count] = '0;
				r.status = STATUS_DONE;
			end
		end
		r.entry_count = shadow_count[3:0];
		return r;
	endfunction

	// Offers one operation and returns at the edge of its transfer. The
	// sender may idle first; valid and payload then hold until the transfer.
	// Stall is sampled on the falling edge, where nothing is changing.
	task automatic send_op(input op_t o);
		bit taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid <= 1'b1;
		op       <= o;
		do begin
			@(negedge clk);
			taken = !op_stall;
			if (taken)
				pending_results.push_back(apply_queue_op(o));
			@(posedge clk);
		end while (!taken);
	endtask

	function automatic op_t make_op(input logic cmd, input logic [31:0] value,
			input logic [31:0] prio);
		op_t o;
		o.cmd           = cmd;
		o.item_value    = value;
		o.item_priority = prio;
		return o;
	endfunction

	// Priorities come often from a narrow band so that ties are common, now
	// and then from the extremes, and otherwise from the whole range.
	function automatic logic [31:0] rand_priority();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return $urandom_range(0, 4) - 2;
		else if (pick < 6)
			case ($urandom_range(0, 3))
				0:       return 32'h7fff_ffff;
				1:       return 32'h8000_0000;
				2:       return 32'h7fff_fffe;
				default: return 32'h8000_0001;
			endcase
		return $urandom;
	endfunction

	// A dequeue on an empty queue must report the empty status and no entry.
	// The value and priority fields are ignored, so they carry junk.
	task automatic test_dequeue_empty();
		send_op(make_op(CMD_DEQUEUE, 32'hffff_ffff, 32'hffff_ffff));
	endtask

	// Fills the queue with the extremes of both fields and with ties,
	// including ties at the highest and the lowest priority.
	task automatic test_fill_extremes_and_ties();
		send_op(make_op(CMD_ENQUEUE, 32'h7fff_ffff, 32'h8000_0000));
		send_op(make_op(CMD_ENQUEUE, 32'h8000_0000, 32'h7fff_ffff));
		send_op(make_op(CMD_ENQUEUE, 32'h0000_0000, 32'h0000_0000));
		send_op(make_op(CMD_ENQUEUE, 32'hffff_ffff, 32'hffff_ffff));
		send_op(make_op(CMD_ENQUEUE, 32'h0000_0011, 32'h0000_0005));
		send_op(make_op(CMD_ENQUEUE, 32'h0000_0012, 32'h0000_0005));
		send_op(make_op(CMD_ENQUEUE, 32'h0000_0013, 32'h7fff_ffff));
		send_op(make_op(CMD_ENQUEUE, 32'h0000_0014, 32'h8000_0000));
	endtask

	// An enqueue on a full queue is dropped, even at the highest priority.
	task automatic test_full_drop();
		send_op(make_op(CMD_ENQUEUE, 32'h5a5a_a5a5, 32'h7fff_ffff));
	endtask

	// Drains the queue in priority order and then dequeues once more.
	task automatic test_drain_order();
		for (int i = 0; i <= DEPTH; i++)
			send_op(make_op(CMD_DEQUEUE, $urandom, $urandom));
	endtask

	// Random traffic in short runs that lean toward filling, toward
	// draining, or neither, so the queue keeps passing through full and
	// empty with random content in between.
	task automatic test_random_traffic(input int n_ops, input int idle, input int stall);
		int   lean;
		logic cmd;
		idle_pct  = idle;
		stall_pct = stall;
		lean      = 2;
		for (int i = 0; i < n_ops; i++) begin
			if (i % 12 == 0)
				lean = $urandom_range(0, 3);
			case (lean)
				0:       cmd = ($urandom_range(0, 9) < 8) ? CMD_ENQUEUE : CMD_DEQUEUE;
				1:       cmd = ($urandom_range(0, 9) < 2) ? CMD_ENQUEUE : CMD_DEQUEUE;
				default: cmd = ($urandom_range(0, 1) == 0) ? CMD_ENQUEUE : CMD_DEQUEUE;
			endcase
			send_op(make_op(cmd, $urandom, rand_priority()));
		end
	endtask

	// The receiver stalls at random at the rate of the current phase.
	always @(posedge clk)
		result_stall <= ($urandom_range(0, 99) < stall_pct);

	task automatic report_field(input string name, input logic [31:0] expected,
			input logic [31:0] actual);
		if (expected !== actual) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h",
				$time, name, expected, actual);
			fail_count++;
		end
	endtask

	// Each result transfer is matched against the oldest pending result.
	always @(negedge clk) begin
		result_t want;
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result transfer with none expected, actual %h",
					$time, result);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				report_field("head_value", want.head_value, result.head_value);
				report_field("head_priority", want.head_priority, result.head_priority);
				report_field("status", 32'(want.status), 32'(result.status));
				report_field("entry_count", 32'(want.entry_count),
					32'(result.entry_count));
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	always @(negedge clk) begin
		if ((op_valid && !op_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t ns: watchdog expired with %0d results pending",
				$time, pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_dequeue_empty();
		test_fill_extremes_and_ties();
		test_full_drop();
		test_drain_order();

		test_random_traffic(260, 0, 0);
		test_random_traffic(260, 61, 0);
		test_random_traffic(260, 0, 61);
		test_random_traffic(260, 27, 27);

		op_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
